>>> rtl/core/diff_drive_odometry_defines.svh
// Assertion macros used by the odometry RTL.
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ODO_ASSERT_SAME(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define ODO_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define ODO_ASSERT_SAME(label, pre, post, msg)
`define ODO_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> rtl/core/ddo_pkg.sv
// Constants and the arctangent table of the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;
	localparam int CORDIC_STEPS = 24;
	localparam int ITER_W = $clog2(CORDIC_STEPS);
	localparam int DIV_STEPS = 34;

	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [31:0] PI_Q29 = 32'd1686629713;
	localparam logic [31:0] HALF_PI_Q29 = 32'd843314857;
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;
	localparam logic [23:0] MPT_RESET = 24'd1678;
	localparam logic [23:0] WB_RESET = 24'd9830;
	localparam logic [13:0] US_PER_S_DIV64 = 14'd15625;

	function automatic logic [28:0] atan_q29(input logic [4:0] idx);
		logic [28:0] v;
		case (idx)
			5'd0: v = 29'd421657428;
			5'd1: v = 29'd248918915;
			5'd2: v = 29'd131521918;
			5'd3: v = 29'd66762579;
			5'd4: v = 29'd33510843;
			5'd5: v = 29'd16771758;
			5'd6: v = 29'd8387925;
			5'd7: v = 29'd4194219;
			5'd8: v = 29'd2097141;
			5'd9: v = 29'd1048575;
			5'd30, 5'd31: v = 29'd0;
			default: v = 29'd1 << (5'd29 - idx);
		endcase
		return v;
	endfunction
endpackage

>>> rtl/core/diff_drive_odometry.sv
// Differential-drive wheel odometer: pose and speed update through one shared sequencer.
// Sequence: an update runs four setup steps, one CORDIC rotation per cycle over CORDIC_STEPS
// iterations, two products and four restoring divisions; with zero elapsed time only the
// heading division runs. A reset item answers next cycle.
// Throughput: one item at a time; the next is taken the cycle after the result transaction.
// arst_n clears pose, speeds, previous counts and time, and reloads the register defaults.
`timescale 1ns / 1ps
`include "diff_drive_odometry_defines.svh"
module diff_drive_odometry
	import ddo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               cmd,
	input  logic signed [31:0] count_left,
	input  logic signed [31:0] count_right,
	input  logic [31:0]        timestamp_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [31:0]        heading,
	output logic signed [31:0] speed_left,
	output logic signed [31:0] speed_right,
	output logic signed [31:0] speed_center,
	output logic signed [31:0] turn_rate,
	output logic [31:0]        time_step,
	output logic               step_zero
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_L, ST_MUL_R, ST_DIST, ST_FOLD, ST_ROT, ST_POS_X, ST_POS_Y,
		ST_DIV_PREP, ST_DIV_RUN, ST_DIV_END, ST_OUT
	} state_t;
	typedef enum logic [1:0] {JOB_HEAD, JOB_LEFT, JOB_RIGHT, JOB_TURN} job_t;

	state_t state_q;
	job_t job_q;
	logic [23:0] mpt_q, wb_q;
	logic [31:0] prev_cl_q, prev_cr_q, prev_time_q;
	logic signed [31:0] pos_x_q, pos_y_q, speed_left_q, speed_right_q, turn_rate_q;
	logic [31:0] heading_q, time_step_q;
	logic step_zero_q;
	logic signed [31:0] dcl_q, dcr_q, dc_q;
	logic signed [56:0] dl_q, dr_q;
	logic signed [33:0] x_q, y_q, ang_q, dth_q;
	logic flip_q;
	logic [ITER_W-1:0] iter_q;
	logic [79:0] rem_q, dvs_q;
	logic [33:0] quo_q;
	logic [5:0] cnt_q;
	logic mzero_q, neg_q;
	logic [31:0] cap_q;

	logic signed [57:0] dsum, drnd;
	logic signed [33:0] fold_a;
	logic fold_flip;
	logic signed [33:0] x_sh, y_sh, atan_v;
	logic signed [33:0] cval;
	logic signed [65:0] prod;
	logic signed [66:0] inc, nsum;
	logic signed [57:0] vv;
	logic [57:0] mag;
	logic [39:0] den;
	logic shift_mode;
	logic [79:0] num;
	logic [33:0] tmag;
	logic signed [33:0] res;
	logic signed [34:0] hsum;
	logic signed [32:0] csum;

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		if (v > 67'sd2147483647)
			return 32'sh7fff_ffff;
		if (v < -67'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {8'd0, wb_q} : {8'd0, mpt_q};
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign heading = heading_q;
	assign speed_left = speed_left_q;
	assign speed_right = speed_right_q;
	assign turn_rate = turn_rate_q;
	assign time_step = time_step_q;
	assign step_zero = step_zero_q;
	assign csum = 33'(speed_left_q) + 33'(speed_right_q);
	assign speed_center = csum[32:1];

	always_comb begin
		dsum = 58'(dl_q) + 58'(dr_q);
		drnd = (dsum + 58'sd256) >>> 9;

		// Fold the heading into [-pi/2, pi/2] and remember to negate the result.
		fold_a = $signed({2'b00, heading_q});
		fold_flip = 1'b0;
		if (fold_a > $signed({2'b00, PI_Q29}))
			fold_a = fold_a - $signed({2'b00, TWO_PI_Q29});
		if (fold_a > $signed({2'b00, HALF_PI_Q29})) begin
			fold_a = fold_a - $signed({2'b00, PI_Q29});
			fold_flip = 1'b1;
		end else if (fold_a < -$signed({2'b00, HALF_PI_Q29})) begin
			fold_a = fold_a + $signed({2'b00, PI_Q29});
			fold_flip = 1'b1;
		end

		x_sh = x_q >>> iter_q;
		y_sh = y_q >>> iter_q;
		atan_v = $signed({5'd0, atan_q29(5'(iter_q))});

		if (state_q == ST_POS_X)
			cval = flip_q ? -x_q : x_q;
		else
			cval = flip_q ? -y_q : y_q;
		prod = 66'(dc_q) * 66'(cval);
		inc = (67'(prod) + (67'sd1 <<< 29)) >>> 30;
		if (state_q == ST_POS_X)
			nsum = 67'(pos_x_q) + inc;
		else
			nsum = 67'(pos_y_q) + inc;

		case (job_q)
			JOB_HEAD: begin
				vv = 58'(dr_q) - 58'(dl_q);
				den = {16'd0, wb_q};
				shift_mode = 1'b1;
			end
			JOB_LEFT: begin
				vv = 58'(dl_q);
				den = {6'd0, time_step_q, 2'b00};
				shift_mode = 1'b0;
			end
			JOB_RIGHT: begin
				vv = 58'(dr_q);
				den = {6'd0, time_step_q, 2'b00};
				shift_mode = 1'b0;
			end
			default: begin
				vv = 58'(dth_q);
				den = {1'b0, time_step_q, 7'd0};
				shift_mode = 1'b0;
			end
		endcase
		mag = vv[57] ? 58'(-vv) : 58'(vv);
		if (shift_mode)
			num = {1'b0, mag, 21'd0};
		else
			num = 80'(mag) * 80'(US_PER_S_DIV64);

		tmag = mzero_q ? 34'd0 : ((quo_q > {2'b00, cap_q}) ? {2'b00, cap_q} : quo_q);
		res = neg_q ? -$signed(tmag) : $signed(tmag);
		hsum = $signed({3'b000, heading_q}) + 35'(res);
		if (hsum >= $signed({3'b000, TWO_PI_Q29}))
			hsum = hsum - $signed({3'b000, TWO_PI_Q29});
		else if (hsum < 35'sd0)
			hsum = hsum + $signed({3'b000, TWO_PI_Q29});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q <= JOB_HEAD;
			mpt_q <= MPT_RESET;
			wb_q <= WB_RESET;
			prev_cl_q <= '0;
			prev_cr_q <= '0;
			prev_time_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			heading_q <= '0;
			speed_left_q <= '0;
			speed_right_q <= '0;
			turn_rate_q <= '0;
			time_step_q <= '0;
			step_zero_q <= 1'b0;
			iter_q <= '0;
			cnt_q <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2])
					wb_q <= pwdata[23:0];
				else
					mpt_q <= pwdata[23:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						prev_time_q <= timestamp_us;
						step_zero_q <= 1'b0;
						if (cmd) begin
							pos_x_q <= '0;
							pos_y_q <= '0;
							heading_q <= '0;
							speed_left_q <= '0;
							speed_right_q <= '0;
							turn_rate_q <= '0;
							state_q <= ST_OUT;
						end else begin
							dcl_q <= count_left - prev_cl_q;
							dcr_q <= count_right - prev_cr_q;
							prev_cl_q <= count_left;
							prev_cr_q <= count_right;
							time_step_q <= timestamp_us - prev_time_q;
							state_q <= ST_MUL_L;
						end
					end
				end
				ST_MUL_L: begin
					dl_q <= dcl_q * $signed({1'b0, mpt_q});
					state_q <= ST_MUL_R;
				end
				ST_MUL_R: begin
					dr_q <= dcr_q * $signed({1'b0, mpt_q});
					state_q <= ST_DIST;
				end
				ST_DIST: begin
					dc_q <= sat32(67'(drnd));
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					ang_q <= fold_a;
					flip_q <= fold_flip;
					x_q <= $signed({4'd0, GAIN_Q30});
					y_q <= '0;
					iter_q <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (!ang_q[33]) begin
						x_q <= x_q - y_sh;
						y_q <= y_q + x_sh;
						ang_q <= ang_q - atan_v;
					end else begin
						x_q <= x_q + y_sh;
						y_q <= y_q - x_sh;
						ang_q <= ang_q + atan_v;
					end
					if (iter_q == ITER_W'(CORDIC_STEPS - 1))
						state_q <= ST_POS_X;
					else
						iter_q <= iter_q + 1'b1;
				end
				ST_POS_X: begin
					pos_x_q <= sat32(nsum);
					state_q <= ST_POS_Y;
				end
				ST_POS_Y: begin
					pos_y_q <= sat32(nsum);
					job_q <= JOB_HEAD;
					state_q <= ST_DIV_PREP;
				end
				ST_DIV_PREP: begin
					rem_q <= num;
					dvs_q <= {7'd0, den, 33'd0};
					quo_q <= '0;
					cnt_q <= '0;
					mzero_q <= (mag == '0);
					neg_q <= vv[57];
					if (job_q == JOB_HEAD)
						cap_q <= vv[57] ? TWO_PI_Q29 : TWO_PI_Q29 - 32'd1;
					else
						cap_q <= vv[57] ? 32'h8000_0000 : 32'h7fff_ffff;
					state_q <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					if (rem_q >= dvs_q) begin
						rem_q <= rem_q - dvs_q;
						quo_q <= {quo_q[32:0], 1'b1};
					end else begin
						quo_q <= {quo_q[32:0], 1'b0};
					end
					dvs_q <= dvs_q >> 1;
					if (cnt_q == 6'(DIV_STEPS - 1))
						state_q <= ST_DIV_END;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				ST_DIV_END: begin
					case (job_q)
						JOB_HEAD: begin
							dth_q <= res;
							heading_q <= hsum[31:0];
							if (time_step_q == '0) begin
								speed_left_q <= '0;
								speed_right_q <= '0;
								turn_rate_q <= '0;
								step_zero_q <= 1'b1;
								state_q <= ST_OUT;
							end else begin
								job_q <= JOB_LEFT;
								state_q <= ST_DIV_PREP;
							end
						end
						JOB_LEFT: begin
							speed_left_q <= res[31:0];
							job_q <= JOB_RIGHT;
							state_q <= ST_DIV_PREP;
						end
						JOB_RIGHT: begin
							speed_right_q <= res[31:0];
							job_q <= JOB_TURN;
							state_q <= ST_DIV_PREP;
						end
						default: begin
							turn_rate_q <= res[31:0];
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ODO_ASSERT_SAME(a_no_overlap, 1'b1, !(in_ready && out_valid), "input and output both open")
	`ODO_ASSERT_SAME(a_heading_range, out_valid, heading < TWO_PI_Q29, "heading out of range")
	`ODO_ASSERT_SAME(a_zero_step_speeds, out_valid && step_zero,
		speed_left == 0 && speed_right == 0 && turn_rate == 0, "speeds not cleared")
	`ODO_ASSERT_NEXT(a_release, out_valid && out_ready, in_ready, "not ready after result")
endmodule
